[sv/jsu_pkg.sv]
// Shared constants, types and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int PhaseW = 4;
    localparam int StatW  = 3;

    localparam logic [PhaseW-1:0] PH_OPEN = 4'd0;
    localparam logic [PhaseW-1:0] PH_BODY = 4'd1;
    localparam logic [PhaseW-1:0] PH_ESC  = 4'd2;
    localparam logic [PhaseW-1:0] PH_HI0  = 4'd3;
    localparam logic [PhaseW-1:0] PH_HI1  = 4'd4;
    localparam logic [PhaseW-1:0] PH_HI2  = 4'd5;
    localparam logic [PhaseW-1:0] PH_HI3  = 4'd6;
    localparam logic [PhaseW-1:0] PH_BSL  = 4'd7;
    localparam logic [PhaseW-1:0] PH_U    = 4'd8;
    localparam logic [PhaseW-1:0] PH_LO0  = 4'd9;
    localparam logic [PhaseW-1:0] PH_LO1  = 4'd10;
    localparam logic [PhaseW-1:0] PH_LO2  = 4'd11;
    localparam logic [PhaseW-1:0] PH_LO3  = 4'd12;

    localparam logic [StatW-1:0] ST_OK      = 3'd0;
    localparam logic [StatW-1:0] ST_NOQUOTE = 3'd1;
    localparam logic [StatW-1:0] ST_HEX     = 3'd2;
    localparam logic [StatW-1:0] ST_SURR    = 3'd3;
    localparam logic [StatW-1:0] ST_ESC     = 3'd4;
    localparam logic [StatW-1:0] ST_CTRL    = 3'd5;
    localparam logic [StatW-1:0] ST_MAX     = ST_CTRL;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HI_SURR_LO = 16'hd800;
    localparam logic [15:0] HI_SURR_HI = 16'hdbff;
    localparam logic [15:0] LO_SURR_LO = 16'hdc00;
    localparam logic [15:0] LO_SURR_HI = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        logic [2:0]      cnt;
    } utf8_enc_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic utf8_enc_t utf8_encode(input logic [20:0] u);
        utf8_enc_t e;
        e = '0;
        if (u < 21'h80) begin
            e.bytes[0] = u[7:0];
            e.cnt      = 3'd1;
        end else if (u < 21'h800) begin
            e.bytes[0] = {3'b110, u[10:6]};
            e.bytes[1] = {2'b10, u[5:0]};
            e.cnt      = 3'd2;
        end else if (u < 21'h10000) begin
            e.bytes[0] = {4'b1110, u[15:12]};
            e.bytes[1] = {2'b10, u[11:6]};
            e.bytes[2] = {2'b10, u[5:0]};
            e.cnt      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, u[20:18]};
            e.bytes[1] = {2'b10, u[17:12]};
            e.bytes[2] = {2'b10, u[11:6]};
            e.bytes[3] = {2'b10, u[5:0]};
            e.cnt      = 3'd4;
        end
        return e;
    endfunction

endpackage

[sv/json_string_unescape_utf8_core.sv]
// Top level: JSON string literal unescaper producing a UTF-8 byte stream.
//
// Channel  | Dir | Signals                       | Content
// s_axis   | in  | tvalid tready tdata[7:0]      | literal byte, zero ends input
// m_axis   | out | tvalid tready tdata[15:0]     | [7:0] out_byte, [10:8] status
//          |     | tuser tlast                   | tuser byte_valid, tlast done_res
//
// One input byte is taken per cycle while the input register is free or is
// being decoded; it waits there and is decoded into the result buffer once
// that buffer is empty or giving out its last request. A byte yields 0 to 4
// results; the buffer shifts out one request per cycle while m_axis_tready
// is high, so a surrogate pair holds the input side as its results drain.
// A new byte is taken while the buffer holds results, as long as the input
// register is free. Reset puts the block in the awaiting-opening-byte state.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [15:0]       high_reg, high_next;
    logic [15:0]       low_reg, low_next;

    logic [3:0][7:0]   res_byte_reg, res_byte_next;
    logic [2:0]        rem_reg, rem_next;
    logic              fin_reg, fin_next;
    logic [StatW-1:0]  stat_reg, stat_next;

    logic              take, load, accept;

    // decode of the registered byte
    logic [7:0]        c;
    logic [4:0]        hv;
    logic [15:0]       code16;
    logic              fin;
    logic [StatW-1:0]  st;
    logic              enc;
    logic [20:0]       cp;
    logic              emit_one;
    logic [7:0]        one_byte;
    utf8_enc_t         utf;

    assign take   = m_axis_tvalid && m_axis_tready;
    assign load   = in_valid_reg && ((rem_reg == 3'd0) || (take && rem_reg == 3'd1));
    assign accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !in_valid_reg || load;

    assign m_axis_tvalid = (rem_reg != 3'd0);
    assign m_axis_tdata  = {5'b0, stat_reg, res_byte_reg[0]};
    assign m_axis_tuser  = !fin_reg;
    assign m_axis_tlast  = fin_reg;

    assign c   = in_byte_reg;
    assign hv  = hex_val(c);
    assign utf = utf8_encode(cp);

    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        fin        = 1'b0;
        st         = ST_OK;
        enc        = 1'b0;
        cp         = '0;
        emit_one   = 1'b0;
        one_byte   = c;
        code16     = '0;
        case (phase_reg)
            PH_BODY:
            begin
                if (c == CH_QUOTE) begin
                    fin = 1'b1;
                end else if (c == 8'h00) begin
                    fin = 1'b1;
                    st  = ST_NOQUOTE;
                end else if (c == CH_BSL) begin
                    phase_next = PH_ESC;
                end else if (c < CH_SPACE) begin
                    fin = 1'b1;
                    st  = ST_CTRL;
                end else begin
                    emit_one = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                emit_one   = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSL, CH_SLASH: one_byte = c;
                    CH_B:    one_byte = 8'h08;
                    CH_F:    one_byte = 8'h0c;
                    CH_N:    one_byte = 8'h0a;
                    CH_R:    one_byte = 8'h0d;
                    CH_T:    one_byte = 8'h09;
                    CH_U:
                    begin
                        emit_one   = 1'b0;
                        high_next  = '0;
                        phase_next = PH_HI0;
                    end
                    default:
                    begin
                        emit_one = 1'b0;
                        fin      = 1'b1;
                        st       = ST_ESC;
                    end
                endcase
            end
            PH_HI0, PH_HI1, PH_HI2, PH_HI3:
            begin
                code16 = {high_reg[11:0], hv[3:0]};
                if (hv[4]) begin
                    fin = 1'b1;
                    st  = ST_HEX;
                end else begin
                    high_next = code16;
                    if (phase_reg != PH_HI3) begin
                        phase_next = phase_reg + 4'd1;
                    end else if (code16 >= HI_SURR_LO && code16 <= HI_SURR_HI) begin
                        phase_next = PH_BSL;
                    end else begin
                        phase_next = PH_BODY;
                        enc        = 1'b1;
                        cp         = {5'b0, code16};
                    end
                end
            end
            PH_BSL:
            begin
                if (c != CH_BSL) begin
                    fin = 1'b1;
                    st  = ST_SURR;
                end else begin
                    phase_next = PH_U;
                end
            end
            PH_U:
            begin
                if (c != CH_U) begin
                    fin = 1'b1;
                    st  = ST_SURR;
                end else begin
                    low_next   = '0;
                    phase_next = PH_LO0;
                end
            end
            PH_LO0, PH_LO1, PH_LO2, PH_LO3:
            begin
                code16 = {low_reg[11:0], hv[3:0]};
                if (hv[4]) begin
                    fin = 1'b1;
                    st  = ST_HEX;
                end else begin
                    low_next = code16;
                    if (phase_reg != PH_LO3) begin
                        phase_next = phase_reg + 4'd1;
                    end else if (code16 < LO_SURR_LO || code16 > LO_SURR_HI) begin
                        fin = 1'b1;
                        st  = ST_SURR;
                    end else begin
                        phase_next = PH_BODY;
                        enc        = 1'b1;
                        // high is D800..DBFF, so high - D800 is its low 10 bits
                        cp         = SUPP_BASE + {1'b0, high_reg[9:0], code16[9:0]};
                    end
                end
            end
            default:
            begin
                phase_next = PH_BODY;
            end
        endcase
        if (fin) phase_next = PH_OPEN;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)    in_valid_next = 1'b1;
        else if (load) in_valid_next = 1'b0;

        res_byte_next = res_byte_reg;
        rem_next      = rem_reg;
        fin_next      = fin_reg;
        stat_next     = stat_reg;
        if (load) begin
            fin_next  = fin;
            stat_next = fin ? st : ST_OK;
            if (fin) begin
                res_byte_next = '0;
                rem_next      = 3'd1;
            end else if (enc) begin
                res_byte_next = utf.bytes;
                rem_next      = utf.cnt;
            end else if (emit_one) begin
                res_byte_next = {24'h0, one_byte};
                rem_next      = 3'd1;
            end else begin
                rem_next      = 3'd0;
            end
        end else if (take) begin
            res_byte_next = {8'h00, res_byte_reg[3:1]};
            rem_next      = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_OPEN;
            high_reg     <= '0;
            low_reg      <= '0;
            rem_reg      <= 3'd0;
            fin_reg      <= 1'b0;
            stat_reg     <= ST_OK;
        end else begin
            in_valid_reg <= in_valid_next;
            rem_reg      <= rem_next;
            fin_reg      <= fin_next;
            stat_reg     <= stat_next;
            if (load) begin
                phase_reg <= phase_next;
                high_reg  <= high_next;
                low_reg   <= low_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) in_byte_reg <= s_axis_tdata;
        res_byte_reg <= res_byte_next;
    end

endmodule

[sv/jsu_checker.sv]
// Port-level checker for the JSON string unescaper, bound to the top level.
`timescale 1ns / 1ps

module jsu_checker
    import jsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // end-of-string request carries no byte
    a_last_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && m_axis_tdata[7:0] == 8'h00)
        else $error("end request carries a byte");

    // status only on the end request
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == ST_OK)
        else $error("status set on a byte request");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[10:8] <= ST_MAX)
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output request changed");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
